FILE: rtl/core/sme_pkg.sv
// Shared types, constants and helpers for the stack machine execution core.
// Used by every module under rtl/core; depends on nothing else.
`default_nettype none

package sme_pkg;

	localparam int STK_DEPTH   = 4;
	localparam int WORD_W      = 32;
	localparam int CNT_W       = 8;
	localparam int ST_W        = 2;
	localparam int DEPTH_W     = $clog2(STK_DEPTH + 1);
	localparam int DEPTH_OUT_W = 3;
	localparam int OP_W        = 3;

	typedef logic [WORD_W-1:0]  word_t;
	typedef logic [CNT_W-1:0]   cnt_t;
	typedef logic [ST_W-1:0]    status_t;
	typedef logic [DEPTH_W-1:0] depth_t;
	typedef logic [OP_W-1:0]    op_t;

	localparam word_t OPCODE_BASE = 32'h8000_0000;
	localparam cnt_t  PLEN_RESET  = 8'd18;

	localparam status_t ST_RUN  = 2'd0;
	localparam status_t ST_HALT = 2'd1;
	localparam status_t ST_ERR  = 2'd2;
	localparam status_t ST_END  = 2'd3;

	localparam op_t OP_HALT  = 3'd0;
	localparam op_t OP_PUSH  = 3'd1;
	localparam op_t OP_POP   = 3'd2;
	localparam op_t OP_COPY  = 3'd3;
	localparam op_t OP_JUMP0 = 3'd4;
	localparam op_t OP_LT    = 3'd5;
	localparam op_t OP_ADD   = 3'd6;

	typedef struct packed {
		word_t instr;
		word_t operand;
	} sme_item_t;

	typedef struct packed {
		cnt_t    counter;
		status_t status;
		word_t   top;
		depth_t  depth;
	} sme_res_t;

	// The depth field shows the whole depth, since DEPTH_OUT_W equals DEPTH_W.
	function automatic logic [DEPTH_OUT_W-1:0] depth_out(depth_t d);
		logic [DEPTH_W+DEPTH_OUT_W-1:0] ext;
		ext = {{DEPTH_OUT_W{1'b0}}, d};
		return ext[DEPTH_OUT_W-1:0];
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/sme_in_reg.sv
// Input register stage of the stack machine execution core.
// Depends on sme_pkg for the item type.
`default_nettype none

module sme_in_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  sme_pkg::sme_item_t item,
	input  logic              advance,
	output logic              in_stall,
	output logic              fire,
	output sme_pkg::sme_item_t item_s1
);
	import sme_pkg::*;

	logic valid_s1;

	// The held item moves on only when the result register can take its result.
	assign in_stall = valid_s1 && !advance;
	assign fire     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= item;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/sme_exec.sv
// Execution stage: machine state registers and the combinational instruction step.
// Depends on sme_pkg for types, opcodes and status codes.
`default_nettype none

module sme_exec (
	input  logic              clk,
	input  logic              arst_n,
	input  sme_pkg::cnt_t     prog_words,
	input  logic              fire,
	input  sme_pkg::sme_item_t item,
	output sme_pkg::sme_res_t res
);
	import sme_pkg::*;

	// Entry 0 is the top of the stack; pushes and pops shift the whole row.
	word_t   stk_q [STK_DEPTH];
	word_t   stk_d [STK_DEPTH];
	depth_t  depth_q, depth_d;
	cnt_t    cnt_q, cnt_d;
	status_t stat_q, stat_d;

	always_comb begin
		word_t            op;
		op_t              op_code;
		logic             op_known;
		logic [CNT_W:0]   cnt_p1;
		logic             last_word;
		cnt_t             cnt_inc1;
		cnt_t             cnt_inc2;
		logic             empty;
		logic             full;
		logic             has_two;
		word_t            alu;

		stk_d   = stk_q;
		depth_d = depth_q;
		cnt_d   = cnt_q;
		stat_d  = stat_q;

		op        = item.instr ^ OPCODE_BASE;
		op_code   = op[OP_W-1:0];
		op_known  = (op <= WORD_W'(OP_ADD));
		cnt_p1    = {1'b0, cnt_q} + (CNT_W+1)'(1);
		last_word = (cnt_p1 >= {1'b0, prog_words});
		cnt_inc1  = cnt_p1[CNT_W-1:0];
		cnt_inc2  = cnt_q + CNT_W'(2);
		empty     = (depth_q == '0);
		full      = (depth_q == DEPTH_W'(STK_DEPTH));
		has_two   = (depth_q >= DEPTH_W'(2));
		alu       = ($signed(stk_q[0]) < $signed(stk_q[1])) ? WORD_W'(1) : '0;
		if (op_code == OP_ADD) begin
			alu = stk_q[0] + stk_q[1];
		end

		if (stat_q != ST_RUN) begin
			// A stopped machine keeps its state until reset.
		end else if (cnt_q >= prog_words) begin
			stat_d = ST_END;
		end else if (!op_known) begin
			stat_d = ST_ERR;
		end else begin
			unique case (op_code)
				OP_HALT: begin
					stat_d = (depth_q == DEPTH_W'(1)) ? ST_HALT : ST_ERR;
				end
				OP_PUSH: begin
					if (full || last_word) begin
						stat_d = ST_ERR;
					end else begin
						stk_d[0] = item.operand;
						for (int i = 1; i < STK_DEPTH; i++) stk_d[i] = stk_q[i-1];
						depth_d = depth_q + DEPTH_W'(1);
						cnt_d   = cnt_inc2;
					end
				end
				OP_POP: begin
					if (empty) begin
						stat_d = ST_ERR;
					end else begin
						for (int i = 0; i < STK_DEPTH - 1; i++) stk_d[i] = stk_q[i+1];
						depth_d = depth_q - DEPTH_W'(1);
						cnt_d   = cnt_inc1;
					end
				end
				OP_COPY: begin
					if (empty || full) begin
						stat_d = ST_ERR;
					end else begin
						for (int i = 1; i < STK_DEPTH; i++) stk_d[i] = stk_q[i-1];
						depth_d = depth_q + DEPTH_W'(1);
						cnt_d   = cnt_inc1;
					end
				end
				OP_JUMP0: begin
					if (empty || last_word) begin
						stat_d = ST_ERR;
					end else begin
						for (int i = 0; i < STK_DEPTH - 1; i++) stk_d[i] = stk_q[i+1];
						depth_d = depth_q - DEPTH_W'(1);
						cnt_d   = (stk_q[0] == '0) ? item.operand[CNT_W-1:0] : cnt_inc2;
					end
				end
				OP_LT, OP_ADD: begin
					if (!has_two) begin
						stat_d = ST_ERR;
					end else begin
						stk_d[0] = alu;
						for (int i = 1; i < STK_DEPTH - 1; i++) stk_d[i] = stk_q[i+1];
						depth_d = depth_q - DEPTH_W'(1);
						cnt_d   = cnt_inc1;
					end
				end
				default: begin
					stat_d = ST_ERR;
				end
			endcase
		end

		if (stat_d == ST_RUN && cnt_d >= prog_words) begin
			stat_d = ST_END;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
			cnt_q   <= '0;
			stat_q  <= ST_RUN;
		end else if (fire) begin
			depth_q <= depth_d;
			cnt_q   <= cnt_d;
			stat_q  <= stat_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			stk_q <= stk_d;
		end
	end

	assign res.counter = cnt_d;
	assign res.status  = stat_d;
	assign res.depth   = depth_d;
	assign res.top     = (depth_d == '0) ? '0 : stk_d[0];

endmodule

`default_nettype wire

FILE: rtl/core/sme_out_reg.sv
// Result register of the stack machine execution core.
// Depends on sme_pkg for the result type.
`default_nettype none

module sme_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  sme_pkg::sme_res_t res,
	input  logic             out_stall,
	output logic             out_valid,
	output logic             advance,
	output sme_pkg::sme_res_t res_q
);
	import sme_pkg::*;

	logic out_valid_q;

	assign out_valid = out_valid_q;
	assign advance   = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/stack_machine_execute_core.sv
// Stack machine execution core, top level.
// Input channel (in_valid/in_stall): one item is the instruction word at the
// current counter and the word after it, fetched by the surrounding logic.
// Output channel (out_valid/out_stall): one result item per input item, giving
// the next fetch address, run status, top of stack and stack depth.
// Write program_length through program_length_we only while the core is idle;
// the core itself does not enforce this. An accepted item waits in the input
// register until the result register can take it; a combinational step then
// updates the state and result registers. One item per cycle unless stalled.
// When the receiver stalls, the result register holds and in_stall rises as
// soon as the input register holds an item, so at most two items wait inside.
// Reset clears the counter, depth and status and sets program_length to 18;
// stack contents are undefined until pushed. Any stop status holds until reset.
// Instantiates sme_in_reg, sme_exec and sme_out_reg; depends on sme_pkg.
`default_nettype none

module stack_machine_execute_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            program_length_we,
	input  logic [sme_pkg::CNT_W-1:0]       program_length,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic signed [sme_pkg::WORD_W-1:0] instruction_word,
	input  logic signed [sme_pkg::WORD_W-1:0] operand_word,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [sme_pkg::CNT_W-1:0]       next_counter,
	output logic [sme_pkg::ST_W-1:0]        run_status,
	output logic signed [sme_pkg::WORD_W-1:0] top_value,
	output logic [sme_pkg::DEPTH_OUT_W-1:0] stack_depth
);
	import sme_pkg::*;

	cnt_t      prog_words_q;
	sme_item_t item;
	sme_item_t item_s1;
	sme_res_t  res;
	sme_res_t  res_q;
	logic      fire;
	logic      advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prog_words_q <= PLEN_RESET;
		end else if (program_length_we) begin
			prog_words_q <= program_length;
		end
	end

	assign item.instr   = instruction_word;
	assign item.operand = operand_word;

	sme_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.item     (item),
		.advance  (advance),
		.in_stall (in_stall),
		.fire     (fire),
		.item_s1  (item_s1)
	);

	sme_exec u_exec (
		.clk        (clk),
		.arst_n     (arst_n),
		.prog_words (prog_words_q),
		.fire       (fire),
		.item       (item_s1),
		.res        (res)
	);

	sme_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.res       (res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.advance   (advance),
		.res_q     (res_q)
	);

	assign next_counter = res_q.counter;
	assign run_status   = res_q.status;
	assign top_value    = res_q.top;
	assign stack_depth  = depth_out(res_q.depth);

`ifndef NO_ASSERTIONS
	// Once the machine stops, every later step reports the same status.
	a_stop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && res.status != ST_RUN) |=> (res.status == $past(res.status)))
		else $error("stop status changed after the machine stopped");

	// The input side only backs up when a finished result is waiting.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a blocked result");

	// A new result appears only after an item has been executed.
	a_out_from_fire: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(fire))
		else $error("result presented without an executed item");

	// An empty stack always shows a zero top value.
	a_empty_top: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && res.depth == '0) |-> (res.top == '0))
		else $error("empty stack with nonzero top value");
`endif

endmodule

`default_nettype wire

FILE: tb/stack_machine_execute_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for stack_machine_execute_core: a directed program, then long random
// instruction streams kept inside the program, one randomly chosen stop, then items sent after it.
// Depends on sme_pkg and the core RTL; reads and writes no files.

module stack_machine_execute_core_tb;
	import sme_pkg::*;

	localparam int IDLE_LIMIT      = 2000;
	localparam int PHASE_ITEMS     = 265;
	localparam int PRESSURE_AT     = 300;
	localparam int PRESSURE_CYCLES = 150;

	typedef struct packed {
		logic [STK_DEPTH-1:0][WORD_W-1:0] stk;
		logic [3:0]                       depth;
		cnt_t                             pc;
		status_t                          status;
		cnt_t                             plen;
	} machine_t;

	typedef struct packed {
		cnt_t                   pc;
		status_t                status;
		word_t                  top;
		logic [DEPTH_OUT_W-1:0] depth;
	} snapshot_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   program_length_we = 1'b0;
	cnt_t                   program_length = PLEN_RESET;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	word_t                  instruction_word = '0;
	word_t                  operand_word = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	cnt_t                   next_counter;
	status_t                run_status;
	word_t                  top_value;
	logic [DEPTH_OUT_W-1:0] stack_depth;

	sme_item_t fetch_q[$];
	snapshot_t snapshot_q[$];
	machine_t  plan_mach;
	machine_t  mirror_mach;
	int        issued = 0;
	int        err_count = 0;
	int        results_seen = 0;
	int        idle_cycles = 0;
	int        in_gap = 0;
	int        in_calm = 0;
	int        out_left = 0;
	int        out_calm = 0;
	bit        pressure_done = 1'b0;

	stack_machine_execute_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.program_length_we(program_length_we),
		.program_length(program_length),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.instruction_word(instruction_word),
		.operand_word(operand_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.next_counter(next_counter),
		.run_status(run_status),
		.top_value(top_value),
		.stack_depth(stack_depth)
	);

	always #10 clk = ~clk;

	function automatic machine_t fresh_machine();
		machine_t m;
		m = '0;
		m.plen = PLEN_RESET;
		return m;
	endfunction

	// Executes one instruction on a machine copy and returns what the core should show after it.
	function automatic snapshot_t step_machine(inout machine_t m, input word_t instr,
			input word_t opnd);
		snapshot_t snap;
		word_t     code;
		word_t     s1;
		word_t     s2;
		int        d;
		logic      last;
		d = int'(m.depth);
		if (m.status == ST_RUN && m.pc >= m.plen) begin
			m.status = ST_END;
		end else if (m.status == ST_RUN) begin
			code = instr - OPCODE_BASE;
			last = (int'(m.pc) + 1) >= int'(m.plen);
			s1 = (d >= 1) ? m.stk[d-1] : '0;
			s2 = (d >= 2) ? m.stk[d-2] : '0;
			if (code[WORD_W-1:OP_W] != '0) begin
				m.status = ST_ERR;
			end else begin
				case (op_t'(code[OP_W-1:0]))
				OP_HALT: begin
					m.status = (d == 1) ? ST_HALT : ST_ERR;
				end
				OP_PUSH: begin
					if (d >= STK_DEPTH || last) begin
						m.status = ST_ERR;
					end else begin
						m.stk[d] = opnd;
						m.depth = 4'(d + 1);
						m.pc = m.pc + 8'd2;
					end
				end
				OP_POP: begin
					if (d < 1) begin
						m.status = ST_ERR;
					end else begin
						m.depth = 4'(d - 1);
						m.pc = m.pc + 8'd1;
					end
				end
				OP_COPY: begin
					if (d < 1 || d >= STK_DEPTH) begin
						m.status = ST_ERR;
					end else begin
						m.stk[d] = s1;
						m.depth = 4'(d + 1);
						m.pc = m.pc + 8'd1;
					end
				end
				OP_JUMP0: begin
					if (d < 1 || last) begin
						m.status = ST_ERR;
					end else begin
						m.depth = 4'(d - 1);
						m.pc = (s1 == '0) ? opnd[CNT_W-1:0] : m.pc + 8'd2;
					end
				end
				OP_LT, OP_ADD: begin
					if (d < 2) begin
						m.status = ST_ERR;
					end else begin
						if (code[OP_W-1:0] == OP_LT)
							m.stk[d-2] = ($signed(s1) < $signed(s2)) ? 32'd1 : 32'd0;
						else
							m.stk[d-2] = s1 + s2;
						m.depth = 4'(d - 1);
						m.pc = m.pc + 8'd1;
					end
				end
				default: begin
					m.status = ST_ERR;
				end
				endcase
			end
			if (m.status == ST_RUN && m.pc >= m.plen)
				m.status = ST_END;
		end
		snap.pc = m.pc;
		snap.status = m.status;
		snap.top = (m.depth != 0) ? m.stk[m.depth - 1] : '0;
		snap.depth = m.depth[DEPTH_OUT_W-1:0];
		return snap;
	endfunction

	// Mostly back-to-back, occasionally a long pause, and now and then a calm run of none.
	function automatic int pick_gap(inout int calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if (r < 3) begin
			calm = $urandom_range(20, 80);
			return 0;
		end
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 50);
	endfunction

	function automatic word_t rand_word();
		case ($urandom_range(0, 7))
		0, 1: return '0;
		2: return 32'h7FFF_FFFF;
		3: return 32'h8000_0000;
		4: return 32'hFFFF_FFFF;
		default: return $urandom;
		endcase
	endfunction

	function automatic word_t plan_top();
		return (plan_mach.depth != 0) ? plan_mach.stk[plan_mach.depth - 1] : '0;
	endfunction

	task automatic send_word(input word_t instr, input word_t opnd);
		sme_item_t it;
		it.instr = instr;
		it.operand = opnd;
		fetch_q.push_back(it);
		void'(step_machine(plan_mach, instr, opnd));
		issued++;
	endtask

	task automatic send_op(input op_t op, input word_t opnd);
		send_word(OPCODE_BASE + word_t'(op), opnd);
	endtask

	// Needs at least five words left before the end of the program.
	task automatic jump_to(input cnt_t target);
		word_t w;
		w = $urandom;
		w[CNT_W-1:0] = target;
		if (plan_mach.depth == STK_DEPTH)
			send_op(OP_POP, $urandom);
		if (plan_mach.depth == 0 || plan_top() != '0)
			send_op(OP_PUSH, '0);
		send_op(OP_JUMP0, w);
	endtask

	task automatic set_depth(input int n);
		while (plan_mach.status == ST_RUN && plan_mach.depth < n)
			send_op(OP_PUSH, rand_word());
		while (plan_mach.status == ST_RUN && plan_mach.depth > n)
			send_op(OP_POP, $urandom);
	endtask

	// One legal instruction, or a jump back once the counter nears the end of the program.
	task automatic random_op();
		op_t   legal[$];
		op_t   op;
		int    d;
		int    lim;
		word_t w;
		d = int'(plan_mach.depth);
		lim = int'(plan_mach.plen) - 7;
		if (int'(plan_mach.pc) > lim) begin
			jump_to(cnt_t'($urandom_range(0, lim)));
			return;
		end
		if (d < STK_DEPTH)
			legal.push_back(OP_PUSH);
		if (d >= 1) begin
			legal.push_back(OP_POP);
			legal.push_back(OP_JUMP0);
		end
		if (d >= 1 && d < STK_DEPTH)
			legal.push_back(OP_COPY);
		if (d >= 2) begin
			legal.push_back(OP_LT);
			legal.push_back(OP_ADD);
		end
		op = legal[$urandom_range(0, legal.size() - 1)];
		w = $urandom;
		if (op == OP_PUSH) begin
			send_op(op, rand_word());
		end else if (op == OP_JUMP0 && plan_top() == '0) begin
			w[CNT_W-1:0] = cnt_t'($urandom_range(0, lim));
			send_op(op, w);
		end else begin
			send_op(op, w);
		end
	endtask

	task automatic wait_drained();
		do begin
			@(negedge clk);
		end while (fetch_q.size() != 0 || in_valid || snapshot_q.size() != 0);
	endtask

	task automatic set_length(input cnt_t len);
		wait_drained();
		@(posedge clk);
		program_length_we <= 1'b1;
		program_length <= len;
		@(posedge clk);
		program_length_we <= 1'b0;
		plan_mach.plen = len;
		mirror_mach.plen = len;
	endtask

	// Brings the machine to one of its stops; expects the counter at zero and a length of 16+.
	task automatic stop_machine();
		cnt_t  len;
		int    d;
		word_t w;
		len = plan_mach.plen;
		case ($urandom_range(0, 7))
		0: begin
			set_depth(1);
			send_op(OP_HALT, $urandom);
		end
		1: begin
			d = $urandom_range(1, 4);
			set_depth((d == 1) ? 0 : d);
			send_op(OP_HALT, $urandom);
		end
		2: begin
			if ($urandom_range(0, 1)) begin
				set_depth(0);
				d = $urandom_range(0, 2);
				send_op((d == 0) ? OP_POP : (d == 1) ? OP_COPY : OP_JUMP0, $urandom);
			end else begin
				set_depth(1);
				send_op($urandom_range(0, 1) ? OP_LT : OP_ADD, $urandom);
			end
		end
		3: begin
			set_depth(STK_DEPTH);
			send_op($urandom_range(0, 1) ? OP_PUSH : OP_COPY, rand_word());
		end
		4: begin
			// The operand would lie beyond the last program word.
			set_depth($urandom_range(1, 3));
			jump_to(len - 8'd1);
			send_op($urandom_range(0, 1) ? OP_PUSH : OP_JUMP0, $urandom);
		end
		5: begin
			do begin
				case ($urandom_range(0, 3))
				0: w = OPCODE_BASE + 32'd7;
				1: w = OPCODE_BASE - 32'd1;
				2: w = '0;
				default: w = $urandom;
				endcase
			end while (w - OPCODE_BASE < 32'd7);
			send_word(w, $urandom);
		end
		6: begin
			set_depth($urandom_range(1, 3));
			if (len < 8'd255 && $urandom_range(0, 1)) begin
				jump_to(cnt_t'($urandom_range(len, 255)));
			end else begin
				jump_to(len - 8'd1);
				send_op($urandom_range(0, 1) ? OP_POP : OP_COPY, $urandom);
			end
		end
		default: begin
			// Shrinking the program under the counter ends the run at the next item.
			set_depth(1);
			send_op(OP_PUSH, rand_word());
			set_length(8'd1);
			send_word($urandom, $urandom);
		end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		sme_item_t it;
		logic      next_valid;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			next_valid = in_valid;
			if (in_valid && !in_stall) begin
				snapshot_q.push_back(step_machine(mirror_mach, instruction_word, operand_word));
				next_valid = 1'b0;
			end
			if (!next_valid) begin
				if (in_gap > 0) begin
					in_gap--;
				end else if (fetch_q.size() != 0) begin
					it = fetch_q.pop_front();
					instruction_word <= it.instr;
					operand_word <= it.operand;
					next_valid = 1'b1;
					in_gap = pick_gap(in_calm);
				end
			end
			in_valid <= next_valid;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		snapshot_t want;
		int        g;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (snapshot_q.size() == 0) begin
					$error("result item with nothing outstanding, next_counter %0d", next_counter);
					err_count++;
				end else begin
					want = snapshot_q.pop_front();
					if (next_counter !== want.pc) begin
						$error("next_counter: expected %0d, got %0d", want.pc, next_counter);
						err_count++;
					end
					if (run_status !== want.status) begin
						$error("run_status: expected %0d, got %0d", want.status, run_status);
						err_count++;
					end
					if (top_value !== want.top) begin
						$error("top_value: expected %h, got %h", want.top, top_value);
						err_count++;
					end
					if (stack_depth !== want.depth) begin
						$error("stack_depth: expected %0d, got %0d", want.depth, stack_depth);
						err_count++;
					end
				end
			end
			// A single long hold-off lets the core fill up and stall its input.
			if (!pressure_done && results_seen >= PRESSURE_AT) begin
				pressure_done = 1'b1;
				out_left = PRESSURE_CYCLES;
			end
			if (out_left > 0) begin
				out_left--;
				out_stall <= 1'b1;
			end else begin
				g = pick_gap(out_calm);
				out_left = (g > 0) ? g - 1 : 0;
				out_stall <= (g > 0);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		int   goal;
		cnt_t len;
		plan_mach = fresh_machine();
		mirror_mach = fresh_machine();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Short program at the reset length: extreme values, wrap-around, both jump outcomes.
		send_op(OP_PUSH, 32'h7FFF_FFFF);
		send_op(OP_PUSH, 32'h8000_0000);
		send_op(OP_LT, $urandom);
		send_op(OP_PUSH, 32'h7FFF_FFFF);
		send_op(OP_ADD, $urandom);
		send_op(OP_COPY, $urandom);
		send_op(OP_COPY, $urandom);
		send_op(OP_COPY, $urandom);
		send_op(OP_LT, $urandom);
		send_op(OP_JUMP0, 32'hFFFF_FF00);
		send_op(OP_JUMP0, 32'h0000_00FF);
		send_op(OP_PUSH, 32'hFFFF_FFFF);
		send_op(OP_LT, $urandom);
		send_op(OP_POP, $urandom);
		send_op(OP_PUSH, 32'h0000_0000);
		send_op(OP_PUSH, 32'h0000_0001);
		send_op(OP_ADD, $urandom);
		send_op(OP_PUSH, 32'h0000_0000);
		send_op(OP_JUMP0, 32'h8000_0003);
		send_op(OP_PUSH, 32'h5555_5555);
		send_op(OP_PUSH, 32'hAAAA_AAAA);
		send_op(OP_ADD, $urandom);
		send_op(OP_LT, $urandom);
		send_op(OP_POP, $urandom);

		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 0 || ph == 5)
				len = 8'd255;
			else if (ph == 1)
				len = 8'd7;
			else
				len = cnt_t'($urandom_range(7, (ph == 2) ? 40 : 255));
			jump_to(8'd0);
			set_length(len);
			goal = issued + PHASE_ITEMS;
			while (issued < goal)
				random_op();
		end

		jump_to(8'd0);
		set_length(cnt_t'($urandom_range(16, 255)));
		stop_machine();

		// Once stopped, the core must ignore whatever arrives.
		repeat (20) send_word($urandom, $urandom);
		send_word('0, '1);
		send_word('1, '0);
		set_length(8'd1);
		repeat (4) send_word($urandom, $urandom);

		wait_drained();
		repeat (4) @(posedge clk);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
